>>> rtl/csf_pkg.sv
// Shared types, codes and defaults for the counting semaphore with a FIFO wait queue.
`default_nettype none

package csf_pkg;

    localparam int DEF_MAX_THREADS = 16;
    localparam int DEF_MAX_COUNT   = 255;

    localparam int THREAD_ID_W = 4;
    localparam int INIT_COUNT_W = 8;
    localparam logic [INIT_COUNT_W-1:0] INIT_COUNT_RESET = 8'd1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_WORD_INIT_COUNT = 1'b0;

    localparam logic MODE_WAIT   = 1'b0;
    localparam logic MODE_SIGNAL = 1'b1;

    localparam logic [2:0] ST_GRANTED     = 3'd0;
    localparam logic [2:0] ST_QUEUED      = 3'd1;
    localparam logic [2:0] ST_REJECTED    = 3'd2;
    localparam logic [2:0] ST_INCREMENTED = 3'd3;
    localparam logic [2:0] ST_WOKE        = 3'd4;
    localparam logic [2:0] ST_SATURATED   = 3'd5;

    typedef struct packed {
        logic                   mode;
        logic [THREAD_ID_W-1:0] thread_id;
    } csf_item_t;

    typedef struct packed {
        logic [2:0]             status;
        logic                   woken_valid;
        logic [THREAD_ID_W-1:0] woken_thread;
        logic [7:0]             count_now;
        logic [4:0]             waiters_now;
    } csf_result_t;

    typedef enum logic [0:0] {
        CSF_IDLE,
        CSF_EXEC
    } csf_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } csf_cmd_t;

endpackage

`default_nettype wire

>>> rtl/csf_ctrl.sv
// Controller state machine that sequences one request beat through the datapath.
`default_nettype none

module csf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output csf_pkg::csf_cmd_t  cmd
);

    csf_pkg::csf_state_t state_reg;
    csf_pkg::csf_state_t state_next;
    logic                done_reg;
    logic                done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csf_pkg::CSF_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            csf_pkg::CSF_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = csf_pkg::CSF_EXEC;
                end
            end
            csf_pkg::CSF_EXEC:
            begin
                busy        = 1'b1;
                cmd.execute = 1'b1;
                done_next   = 1'b1;
                state_next  = csf_pkg::CSF_IDLE;
            end
            default:
            begin
                state_next = csf_pkg::CSF_IDLE;
            end
        endcase
    end

    assign done = done_reg;

    // Every result beat follows an execute cycle.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == csf_pkg::CSF_EXEC))
        else $error("result beat without a preceding execute cycle");

endmodule

`default_nettype wire

>>> rtl/csf_datapath.sv
// Datapath holding the count, the wait-queue ring, the waiting flags and the result register.
`default_nettype none

module csf_datapath #(
    parameter int MAX_THREADS = csf_pkg::DEF_MAX_THREADS,
    parameter int MAX_COUNT   = csf_pkg::DEF_MAX_COUNT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire csf_pkg::csf_cmd_t                   cmd,
    input  wire csf_pkg::csf_item_t                  item,
    input  wire logic                                cfg_write,
    input  wire logic [csf_pkg::INIT_COUNT_W-1:0]    cfg_data,
    output logic [csf_pkg::INIT_COUNT_W-1:0]         init_count,
    output csf_pkg::csf_result_t                     result
);

    localparam int IDXW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int LENW = $clog2(MAX_THREADS + 1);
    localparam int CNTW = $clog2(MAX_COUNT + 1);

    logic [csf_pkg::INIT_COUNT_W-1:0] init_count_reg;
    logic [CNTW-1:0]                  count_reg;
    logic [CNTW-1:0]                  count_next;
    logic [IDXW-1:0]                  head_reg;
    logic [IDXW-1:0]                  head_next;
    logic [IDXW-1:0]                  tail_reg;
    logic [IDXW-1:0]                  tail_next;
    logic [LENW-1:0]                  len_reg;
    logic [LENW-1:0]                  len_next;
    logic [MAX_THREADS-1:0]           flags_reg;
    logic [MAX_THREADS-1:0]           flags_next;
    csf_pkg::csf_item_t               item_reg;
    csf_pkg::csf_result_t             result_reg;
    csf_pkg::csf_result_t             result_next;

    logic [csf_pkg::THREAD_ID_W-1:0]  queue_mem [MAX_THREADS];
    logic [csf_pkg::THREAD_ID_W-1:0]  head_rd_reg;

    logic                             enqueue;
    logic [IDXW-1:0]                  tid_idx;
    logic                             tid_ok;
    logic [CNTW-1:0]                  cfg_count;

    assign tid_idx   = IDXW'(item_reg.thread_id);
    assign tid_ok    = (32'(item_reg.thread_id) < MAX_THREADS);
    assign cfg_count = (32'(cfg_data) > MAX_COUNT) ? CNTW'(MAX_COUNT) : CNTW'(cfg_data);

    always_comb
    begin
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        len_next    = len_reg;
        flags_next  = flags_reg;
        enqueue     = 1'b0;
        result_next = '0;
        if (item_reg.mode == csf_pkg::MODE_WAIT)
        begin
            if (!tid_ok || flags_reg[tid_idx])
            begin
                result_next.status = csf_pkg::ST_REJECTED;
            end
            else if (count_reg != '0)
            begin
                count_next         = count_reg - CNTW'(1);
                result_next.status = csf_pkg::ST_GRANTED;
            end
            else if (len_reg >= LENW'(MAX_THREADS))
            begin
                result_next.status = csf_pkg::ST_REJECTED;
            end
            else
            begin
                enqueue             = 1'b1;
                flags_next[tid_idx] = 1'b1;
                tail_next           = (tail_reg == IDXW'(MAX_THREADS - 1)) ? '0
                                                                         : tail_reg + IDXW'(1);
                len_next            = len_reg + LENW'(1);
                result_next.status  = csf_pkg::ST_QUEUED;
            end
        end
        else
        begin
            if (len_reg != '0)
            begin
                head_next                        = (head_reg == IDXW'(MAX_THREADS - 1)) ? '0
                                                                         : head_reg + IDXW'(1);
                len_next                         = len_reg - LENW'(1);
                flags_next[IDXW'(head_rd_reg)]   = 1'b0;
                result_next.woken_valid          = 1'b1;
                result_next.woken_thread         = head_rd_reg;
                result_next.status               = csf_pkg::ST_WOKE;
            end
            else if (32'(count_reg) >= MAX_COUNT)
            begin
                result_next.status = csf_pkg::ST_SATURATED;
            end
            else
            begin
                count_next         = count_reg + CNTW'(1);
                result_next.status = csf_pkg::ST_INCREMENTED;
            end
        end
        result_next.count_now   = 8'(count_next);
        result_next.waiters_now = 5'(len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_count_reg <= csf_pkg::INIT_COUNT_RESET;
            count_reg      <= CNTW'(1);
            head_reg       <= '0;
            tail_reg       <= '0;
            len_reg        <= '0;
            flags_reg      <= '0;
        end
        else if (cfg_write)
        begin
            init_count_reg <= cfg_data;
            count_reg      <= cfg_count;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            len_reg   <= len_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.execute)
        begin
            result_reg <= result_next;
        end
    end

    // The head entry is read every cycle, so it is ready by the execute cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && enqueue)
        begin
            queue_mem[tail_reg] <= item_reg.thread_id;
        end
        head_rd_reg <= queue_mem[head_reg];
    end

    assign init_count = init_count_reg;
    assign result     = result_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LENW'(MAX_THREADS))
        else $error("wait queue length exceeds its depth");

    a_flags_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(flags_reg) == 32'(len_reg))
        else $error("waiting flags disagree with queue length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_COUNT)
        else $error("count exceeds its maximum");

endmodule

`default_nettype wire

>>> rtl/counting_semaphore_fifo.sv
// Top level of the counting semaphore with a FIFO wait queue and its register port.
//
//   Channel   Handshake                         Payload
//   request   start in, busy out                item   (mode, thread_id)
//   result    done out, one cycle, no stall     result (status, woken, count, waiters)
//   config    APB psel/penable/pwrite, pready   paddr, pwdata, prdata (initial_count)
//
// A request beat is taken when start is high and busy is low; busy then stays high
// for one execute cycle, so no new beat is taken while the last one executes.
// The result beat appears on done in the cycle after the execute cycle.
// The split into a capture step and an execute step comes from the registered read of the wait-queue memory.
// Reset clears the queue and flags and loads the count with one; no clearing pass.
// The receiver cannot stall; every result beat must be taken as it appears.
`default_nettype none

module counting_semaphore_fifo #(
    parameter int MAX_THREADS = csf_pkg::DEF_MAX_THREADS,
    parameter int MAX_COUNT   = csf_pkg::DEF_MAX_COUNT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire csf_pkg::csf_item_t                item,
    output logic                                   done,
    output csf_pkg::csf_result_t                   result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [csf_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [csf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [csf_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    csf_pkg::csf_cmd_t                  cmd;
    logic                               cfg_write;
    logic                               sel_init;
    logic [csf_pkg::INIT_COUNT_W-1:0]   init_count;

    assign pready    = 1'b1;
    assign sel_init  = (paddr[csf_pkg::APB_ADDR_W-1] == csf_pkg::REG_WORD_INIT_COUNT);
    assign cfg_write = psel && penable && pwrite && sel_init;
    assign prdata    = sel_init ? csf_pkg::APB_DATA_W'(init_count) : '0;

    csf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    csf_datapath #(
        .MAX_THREADS (MAX_THREADS),
        .MAX_COUNT   (MAX_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item       (item),
        .cfg_write  (cfg_write),
        .cfg_data   (pwdata[csf_pkg::INIT_COUNT_W-1:0]),
        .init_count (init_count),
        .result     (result)
    );

endmodule

`default_nettype wire

>>> tb/counting_semaphore_fifo_test.sv
// Self-checking testbench for the counting semaphore with a FIFO wait queue, with its own predictor.
module counting_semaphore_fifo_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 850;
    localparam logic [csf_pkg::APB_ADDR_W-1:0] INIT_COUNT_ADDR =
        {csf_pkg::REG_WORD_INIT_COUNT, 2'b00};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    csf_pkg::csf_item_t item = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [csf_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [csf_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic busy;
    logic done;
    logic pready;
    csf_pkg::csf_result_t result;
    logic [csf_pkg::APB_DATA_W-1:0] prdata;

    logic [7:0] sem_count;
    logic [csf_pkg::THREAD_ID_W-1:0] wait_ring [csf_pkg::DEF_MAX_THREADS];
    logic [csf_pkg::THREAD_ID_W-1:0] ring_head;
    logic [csf_pkg::THREAD_ID_W-1:0] ring_tail;
    logic [4:0] ring_len;
    logic [csf_pkg::DEF_MAX_THREADS-1:0] waiting;
    csf_pkg::csf_result_t owed_replies[$];
    int failures = 0;
    int cycles = 0;
    bit gaps_on = 1'b1;

    counting_semaphore_fifo DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic csf_pkg::csf_result_t apply_op(csf_pkg::csf_item_t op);
        csf_pkg::csf_result_t r;
        r = '0;
        if (op.mode == csf_pkg::MODE_WAIT)
        begin
            if (waiting[op.thread_id])
                r.status = csf_pkg::ST_REJECTED;
            else if (sem_count != 8'd0)
            begin
                sem_count = sem_count - 8'd1;
                r.status = csf_pkg::ST_GRANTED;
            end
            else if (ring_len >= csf_pkg::DEF_MAX_THREADS)
                r.status = csf_pkg::ST_REJECTED;
            else
            begin
                waiting[op.thread_id] = 1'b1;
                wait_ring[ring_tail] = op.thread_id;
                ring_tail = ring_tail + 1'b1;
                ring_len = ring_len + 5'd1;
                r.status = csf_pkg::ST_QUEUED;
            end
        end
        else
        begin
            if (ring_len != 5'd0)
            begin
                r.woken_thread = wait_ring[ring_head];
                r.woken_valid = 1'b1;
                ring_head = ring_head + 1'b1;
                ring_len = ring_len - 5'd1;
                waiting[r.woken_thread] = 1'b0;
                r.status = csf_pkg::ST_WOKE;
            end
            else if (sem_count == 8'(csf_pkg::DEF_MAX_COUNT))
                r.status = csf_pkg::ST_SATURATED;
            else
            begin
                sem_count = sem_count + 8'd1;
                r.status = csf_pkg::ST_INCREMENTED;
            end
        end
        r.count_now = sem_count;
        r.waiters_now = ring_len;
        return r;
    endfunction

    always @(posedge clk)
    begin
        csf_pkg::csf_result_t want;
        if (rst_n && done)
        begin
            if (owed_replies.size() == 0)
            begin
                $error("unexpected result beat: status %0d", result.status);
                failures++;
            end
            else
            begin
                want = owed_replies.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    failures++;
                end
                if (result.woken_valid !== want.woken_valid)
                begin
                    $error("woken_valid: expected %0d, got %0d",
                           want.woken_valid, result.woken_valid);
                    failures++;
                end
                if (result.woken_thread !== want.woken_thread)
                begin
                    $error("woken_thread: expected %0d, got %0d",
                           want.woken_thread, result.woken_thread);
                    failures++;
                end
                if (result.count_now !== want.count_now)
                begin
                    $error("count_now: expected %0d, got %0d", want.count_now, result.count_now);
                    failures++;
                end
                if (result.waiters_now !== want.waiters_now)
                begin
                    $error("waiters_now: expected %0d, got %0d",
                           want.waiters_now, result.waiters_now);
                    failures++;
                end
            end
        end
    end

    task automatic send_op(input logic mode, input logic [csf_pkg::THREAD_ID_W-1:0] tid);
        csf_pkg::csf_item_t op;
        op.mode = mode;
        op.thread_id = tid;
        if (gaps_on && $urandom_range(0, 99) < 21)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        item <= op;
        do @(posedge clk); while (busy);
        owed_replies.push_back(apply_op(op));
    endtask

    task automatic settle();
        start <= 1'b0;
        while (owed_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_initial_count(input logic [7:0] value);
        logic [csf_pkg::APB_DATA_W-1:0] seen;
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= INIT_COUNT_ADDR;
        pwdata <= {24'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sem_count = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        seen = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (seen[7:0] !== value)
        begin
            $error("initial_count: expected %0d, got %0d", value, seen[7:0]);
            failures++;
        end
    endtask

    task automatic test_grant_and_queue();
        send_op(csf_pkg::MODE_WAIT, 4'd0);
        send_op(csf_pkg::MODE_WAIT, 4'd15);
        send_op(csf_pkg::MODE_WAIT, 4'd15);
        send_op(csf_pkg::MODE_WAIT, 4'd10);
        send_op(csf_pkg::MODE_SIGNAL, 4'd0);
        send_op(csf_pkg::MODE_SIGNAL, 4'd15);
        send_op(csf_pkg::MODE_SIGNAL, 4'd7);
    endtask

    task automatic test_saturation();
        write_initial_count(8'd254);
        send_op(csf_pkg::MODE_SIGNAL, 4'd0);
        send_op(csf_pkg::MODE_SIGNAL, 4'd9);
        send_op(csf_pkg::MODE_WAIT, 4'd5);
    endtask

    task automatic test_reload_keeps_queue();
        write_initial_count(8'd0);
        send_op(csf_pkg::MODE_WAIT, 4'd3);
        send_op(csf_pkg::MODE_WAIT, 4'd12);
        write_initial_count(8'd2);
        send_op(csf_pkg::MODE_WAIT, 4'd7);
        send_op(csf_pkg::MODE_WAIT, 4'd3);
        send_op(csf_pkg::MODE_SIGNAL, 4'd0);
        send_op(csf_pkg::MODE_SIGNAL, 4'd0);
        send_op(csf_pkg::MODE_SIGNAL, 4'd0);
    endtask

    task automatic test_random_traffic();
        int issued;
        int phase;
        int bias;
        int span;
        issued = 0;
        phase = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (phase == 0 || $urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: write_initial_count(8'd0);
                    1: write_initial_count(8'd1);
                    2: write_initial_count(8'd254);
                    3: write_initial_count(8'd255);
                    default: write_initial_count(8'($urandom_range(0, 255)));
                endcase
            end
            case ($urandom_range(0, 2))
                0: bias = 85;
                1: bias = 50;
                default: bias = 15;
            endcase
            gaps_on = (phase != 3);
            span = $urandom_range(20, 60);
            repeat (span)
            begin
                send_op(($urandom_range(0, 99) < bias) ? csf_pkg::MODE_WAIT
                                                       : csf_pkg::MODE_SIGNAL,
                        csf_pkg::THREAD_ID_W'($urandom_range(0, 15)));
                issued++;
            end
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        sem_count = csf_pkg::INIT_COUNT_RESET;
        ring_head = '0;
        ring_tail = '0;
        ring_len = '0;
        waiting = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_grant_and_queue();
        test_saturation();
        test_reload_keeps_queue();
        test_random_traffic();

        start <= 1'b0;
        for (int i = 0; i < 200 && owed_replies.size() != 0; i++) @(posedge clk);
        repeat (8) @(posedge clk);
        if (owed_replies.size() != 0)
        begin
            $error("%0d result beats never arrived", owed_replies.size());
            failures++;
        end
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
